// ----- rtl/wgs_pkg.sv -----
// Shared types, constants and helper functions for the wave grid stencil block.
package wgs_pkg;

    localparam int GRID_SIZE = 256;
    localparam int CW        = $clog2(GRID_SIZE);
    localparam int AW        = 2 * CW;
    localparam int CELLS     = GRID_SIZE * GRID_SIZE;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [15:0] FOAM_MAX = 16'd65535;

    // Input kinds carried on tuser.
    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_READ = 2'd1,
        MODE_STEP = 2'd2
    } t_mode;

    // Register indexes (byte address / 4).
    localparam logic [2:0] REG_WAVE_GAIN      = 3'd0;
    localparam logic [2:0] REG_VELOCITY_DECAY = 3'd1;
    localparam logic [2:0] REG_HEIGHT_GAIN    = 3'd2;
    localparam logic [2:0] REG_FOLD_GAIN      = 3'd3;
    localparam logic [2:0] REG_FOLD_OFFSET    = 3'd4;
    localparam logic [2:0] REG_GEN_AMOUNT     = 3'd5;
    localparam logic [2:0] REG_SPATIAL_BLEND  = 3'd6;
    localparam logic [2:0] REG_TEMPORAL_RET   = 3'd7;

    // One grid cell as stored in memory.
    typedef struct packed {
        logic        [15:0] foam;
        logic signed [31:0] vel;
        logic signed [31:0] height;
    } t_cell;

    localparam int CELL_W = $bits(t_cell);

    typedef struct packed {
        logic        [23:0] wave_gain;
        logic        [16:0] velocity_decay;
        logic        [23:0] height_gain;
        logic        [23:0] fold_gain;
        logic signed [24:0] fold_offset;
        logic        [23:0] generation_amount;
        logic        [16:0] spatial_blend;
        logic        [16:0] temporal_retention;
    } t_cfg;

    // Border fade by edge distance: e / (0.12 * GRID_SIZE), floored, capped at 1.0.
    localparam int FADE_N = 256;
    typedef logic [FADE_N-1:0][16:0] t_fade_tab;

    function automatic t_fade_tab fade_build();
        t_fade_tab tab;
        longint    f;
        for (int i = 0; i < FADE_N; i++) begin
            f = (longint'(i) * 64'd6553600) / (12 * GRID_SIZE);
            if (f > 65536) f = 65536;
            tab[i] = 17'(f);
        end
        return tab;
    endfunction

    localparam t_fade_tab FADE_TAB = fade_build();

    function automatic logic [16:0] fade_of(logic [CW-1:0] e);
        if (32'(e) >= FADE_N) return ONE_Q16;
        return FADE_TAB[8'(e)];
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic [16:0] cap_one(logic [16:0] f);
        return (f > ONE_Q16) ? ONE_Q16 : f;
    endfunction

endpackage

// ----- rtl/wgs_ram.sv -----
// Generic synchronous RAM: one write port, two read ports, registered read data.
module wgs_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

// ----- rtl/wgs_cell_calc.sv -----
// Multi-cycle per-cell update: velocity, height, border fade, foam generation and blend.
module wgs_cell_calc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  wgs_pkg::t_cfg       i_cfg,
    input  wgs_pkg::t_cell      i_cent,
    input  logic signed [33:0]  i_hsum,
    input  logic        [17:0]  i_fsum,
    input  logic        [16:0]  i_fade,
    output logic                o_done,
    output wgs_pkg::t_cell      o_cell
);
    import wgs_pkg::*;

    typedef enum logic [4:0] {
        C_IDLE, C_LAP, C_MUL1, C_VEL0, C_MUL2, C_VEL1, C_MUL3, C_HGT, C_MUL4,
        C_FADE, C_CLIP, C_RECIP, C_CORR, C_GEN1, C_GEN2, C_GEN3, C_FOAM
    } t_cstate;

    t_cstate r_state;

    logic signed [34:0] r_lap;
    logic signed [59:0] r_pw;
    logic        [58:0] r_pf;
    logic signed [36:0] r_pb;
    logic signed [44:0] r_v0;
    logic        [16:0] r_cand;
    logic signed [20:0] r_mixed;
    logic signed [62:0] r_pd;
    logic signed [38:0] r_pk;
    logic signed [31:0] r_v;
    logic signed [31:0] r_h;
    logic signed [20:0] r_fk;
    logic signed [56:0] r_ph;
    logic signed [49:0] r_phf;
    logic signed [49:0] r_pvf;
    logic        [19:0] r_cx;
    logic        [19:0] r_rx;
    logic               r_csat;
    logic               r_rsat;
    logic        [15:0] r_cq;
    logic        [15:0] r_rq;
    logic        [16:0] r_crest;
    logic        [16:0] r_rise;
    logic        [40:0] r_pg;

    logic        [16:0] decay, blend, keep;
    logic        [17:0] own4;
    logic signed [34:0] lap_c;
    logic        [34:0] fold;
    logic signed [18:0] diff_c;
    logic        [58:0] pf_rnd;
    logic signed [45:0] cand_c;
    logic signed [39:0] crest_x, rise_x;
    logic        [19:0] crem, rrem;
    logic        [40:0] gen_c;
    logic signed [25:0] foam_c;

    always_comb begin
        decay   = cap_one(i_cfg.velocity_decay);
        blend   = cap_one(i_cfg.spatial_blend);
        keep    = cap_one(i_cfg.temporal_retention);
        own4    = {i_cent.foam, 2'b00};
        lap_c   = 35'(i_hsum) - (35'(i_cent.height) <<< 2);
        fold    = r_lap[34] ? 35'(-r_lap) : '0;
        diff_c  = $signed({1'b0, i_fsum}) - $signed({1'b0, own4});
        pf_rnd  = (r_pf + 59'd32768) >> 16;
        cand_c  = $signed({3'b000, pf_rnd[42:0]}) - 46'(i_cfg.fold_offset);
        crest_x = 40'(r_h) * 40'sd100 - 40'sd65536;
        rise_x  = 40'(r_v) * 40'sd100 + 40'sd131072;
        crem    = r_cx - 20'({4'b0000, r_cq}) * 20'd15;
        rrem    = r_rx - 20'({4'b0000, r_rq}) * 20'd12;
        gen_c   = (r_pg + 41'd32768) >> 16;
        foam_c  = 26'(r_fk) + $signed({1'b0, gen_c[24:0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) r_state <= C_LAP;
                end
                C_LAP: begin
                    r_lap   <= lap_c;
                    r_state <= C_MUL1;
                end
                C_MUL1: begin
                    r_pw    <= r_lap * $signed({1'b0, i_cfg.wave_gain});
                    r_pf    <= fold * i_cfg.fold_gain;
                    r_pb    <= diff_c * $signed({1'b0, blend});
                    r_state <= C_VEL0;
                end
                C_VEL0: begin
                    r_v0 <= 45'(i_cent.vel) + 45'((r_pw + 60'sd32768) >>> 16);
                    if (cand_c < 0)                        r_cand <= '0;
                    else if (cand_c > 46'sd65536)          r_cand <= ONE_Q16;
                    else                                   r_cand <= cand_c[16:0];
                    r_mixed <= $signed({3'b000, own4}) + 21'((r_pb + 37'sd32768) >>> 16);
                    r_state <= C_MUL2;
                end
                C_MUL2: begin
                    r_pd    <= r_v0 * $signed({1'b0, decay});
                    r_pk    <= r_mixed * $signed({1'b0, keep});
                    r_state <= C_VEL1;
                end
                C_VEL1: begin
                    r_v     <= sat32(64'((r_pd + 63'sd32768) >>> 16));
                    r_fk    <= 21'((r_pk + 39'sd131072) >>> 18);
                    r_state <= C_MUL3;
                end
                C_MUL3: begin
                    r_ph    <= r_v * $signed({1'b0, i_cfg.height_gain});
                    r_state <= C_HGT;
                end
                C_HGT: begin
                    r_h     <= sat32(64'(i_cent.height) + 64'((r_ph + 57'sd32768) >>> 16));
                    r_state <= C_MUL4;
                end
                C_MUL4: begin
                    r_phf   <= r_h * $signed({1'b0, i_fade});
                    r_pvf   <= r_v * $signed({1'b0, i_fade});
                    r_state <= C_FADE;
                end
                C_FADE: begin
                    r_h     <= sat32(64'((r_phf + 50'sd32768) >>> 16));
                    r_v     <= sat32(64'((r_pvf + 50'sd32768) >>> 16));
                    r_state <= C_CLIP;
                end
                C_CLIP: begin
                    // crest = (100h - 1.0) / 15, rise = (100v + 2.0) / 12, clamped 0..1
                    r_csat <= (crest_x >= 40'sd983040);
                    r_cx   <= (crest_x <= 0 || crest_x >= 40'sd983040) ? '0 : crest_x[19:0];
                    r_rsat <= (rise_x >= 40'sd786432);
                    r_rx   <= (rise_x <= 0 || rise_x >= 40'sd786432) ? '0 : rise_x[19:0];
                    r_state <= C_RECIP;
                end
                C_RECIP: begin
                    // reciprocal estimate, low by at most one
                    r_cq    <= 16'((37'(r_cx) * 37'd69905) >> 20);
                    r_rq    <= 16'((37'(r_rx) * 37'd87381) >> 20);
                    r_state <= C_CORR;
                end
                C_CORR: begin
                    r_crest <= r_csat ? ONE_Q16 : 17'(r_cq) + ((crem >= 20'd15) ? 17'd1 : 17'd0);
                    r_rise  <= r_rsat ? ONE_Q16 : 17'(r_rq) + ((rrem >= 20'd12) ? 17'd1 : 17'd0);
                    r_state <= C_GEN1;
                end
                C_GEN1: begin
                    r_pg    <= 41'(r_cand) * 41'(r_crest);
                    r_state <= C_GEN2;
                end
                C_GEN2: begin
                    r_pg    <= 41'(gen_c[16:0]) * 41'(r_rise);
                    r_state <= C_GEN3;
                end
                C_GEN3: begin
                    r_pg    <= 41'(gen_c[16:0]) * 41'(i_cfg.generation_amount);
                    r_state <= C_FOAM;
                end
                C_FOAM: begin
                    if (foam_c < 0)                    o_cell.foam <= '0;
                    else if (foam_c > 26'sd65535)      o_cell.foam <= FOAM_MAX;
                    else                               o_cell.foam <= foam_c[15:0];
                    o_cell.vel    <= r_v;
                    o_cell.height <= r_h;
                    o_done        <= 1'b1;
                    r_state       <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/wave_grid_stencil_step.sv -----
// Top level of the wave grid stencil block: stream ports, APB registers, sequencer.
//
// Height, velocity and foam of every cell live in two banks of one 80-bit
// word per cell; one bank holds the current grid, the other receives the
// next one, and the roles swap when a substep ends, so no copy-back pass is
// needed. After reset a clearing pass writes zero to the current bank, one
// cell per cycle, over all cells of the 256 x 256 grid; no transfer is taken
// meanwhile (register writes are). An add or read item passes through the
// accepting state, one memory access in S_PT, and S_DONE, which hands the
// result to the output register. For each cell of a substep, S_RD0 to S_RD3
// fetch the center and four neighbors through the two read ports of the
// source bank, and S_CALC waits on the multi-cycle cell unit, whose chain of
// dependent products sets the pace. Each item gives exactly one result
// transfer, all zero except for a read. The output register lets the next
// item be taken while a result still waits on m_axis.
module wave_grid_stencil_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // cell_x[7:0], cell_y[15:8], height_add[47:16],
                                       // velocity_add[79:48]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // height_out[31:0], velocity_out[63:32],
                                       // foam_out[79:64]
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wgs_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PT, S_RD0, S_RD1, S_RD2, S_RD3, S_CALC, S_DONE
    } t_state;

    localparam logic [CW-1:0] MAXC = CW'(GRID_SIZE - 1);

    t_state             r_state;
    logic               r_bank;        // bank holding the current grid
    logic [AW-1:0]      r_clr_cnt;
    logic [CW-1:0]      r_x, r_y;
    logic [1:0]         r_mode;
    logic [AW-1:0]      r_addr;
    logic signed [31:0] r_dh, r_dv;
    t_cell              r_cent;
    logic signed [33:0] r_hsum;
    logic [17:0]        r_fsum;
    logic [16:0]        r_fade;
    t_cell              r_res;
    logic               r_out_valid;
    t_cell              r_out_data;
    t_cfg               r_cfg;

    // ---------------- register port ----------------
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_gain          <= '0;
            r_cfg.velocity_decay     <= ONE_Q16;
            r_cfg.height_gain        <= '0;
            r_cfg.fold_gain          <= '0;
            r_cfg.fold_offset        <= '0;
            r_cfg.generation_amount  <= '0;
            r_cfg.spatial_blend      <= '0;
            r_cfg.temporal_retention <= ONE_Q16;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_WAVE_GAIN:      r_cfg.wave_gain          <= pwdata[23:0];
                REG_VELOCITY_DECAY: r_cfg.velocity_decay     <= pwdata[16:0];
                REG_HEIGHT_GAIN:    r_cfg.height_gain        <= pwdata[23:0];
                REG_FOLD_GAIN:      r_cfg.fold_gain          <= pwdata[23:0];
                REG_FOLD_OFFSET:    r_cfg.fold_offset        <= pwdata[24:0];
                REG_GEN_AMOUNT:     r_cfg.generation_amount  <= pwdata[23:0];
                REG_SPATIAL_BLEND:  r_cfg.spatial_blend      <= pwdata[16:0];
                REG_TEMPORAL_RET:   r_cfg.temporal_retention <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_WAVE_GAIN:      prdata = 32'(r_cfg.wave_gain);
            REG_VELOCITY_DECAY: prdata = 32'(r_cfg.velocity_decay);
            REG_HEIGHT_GAIN:    prdata = 32'(r_cfg.height_gain);
            REG_FOLD_GAIN:      prdata = 32'(r_cfg.fold_gain);
            REG_FOLD_OFFSET:    prdata = 32'(r_cfg.fold_offset);
            REG_GEN_AMOUNT:     prdata = 32'(r_cfg.generation_amount);
            REG_SPATIAL_BLEND:  prdata = 32'(r_cfg.spatial_blend);
            REG_TEMPORAL_RET:   prdata = 32'(r_cfg.temporal_retention);
            default:            prdata = '0;
        endcase
    end

    // ---------------- addressing ----------------
    logic [CW-1:0] in_x, in_y;
    logic [CW-1:0] x_lo, x_hi, y_lo, y_hi, ex, ey, edge_d;
    logic          s_xfer;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        // out-of-grid coordinates clamp to the last row/column
        in_x   = (32'(s_axis_tdata[7:0])  > GRID_SIZE - 1) ? MAXC : CW'(s_axis_tdata[7:0]);
        in_y   = (32'(s_axis_tdata[15:8]) > GRID_SIZE - 1) ? MAXC : CW'(s_axis_tdata[15:8]);
        x_lo   = (r_x == '0)   ? r_x : r_x - 1'b1;
        x_hi   = (r_x == MAXC) ? r_x : r_x + 1'b1;
        y_lo   = (r_y == '0)   ? r_y : r_y - 1'b1;
        y_hi   = (r_y == MAXC) ? r_y : r_y + 1'b1;
        ex     = (r_x < MAXC - r_x) ? r_x : MAXC - r_x;
        ey     = (r_y < MAXC - r_y) ? r_y : MAXC - r_y;
        edge_d = (ex < ey) ? ex : ey;
    end

    // ---------------- memory banks ----------------
    logic [AW-1:0]     rd_addr_a, rd_addr_b;
    logic [CELL_W-1:0] rd_a [2];
    logic [CELL_W-1:0] rd_b [2];
    t_cell             dat_a, dat_b;
    logic              wr_en, wr_bank;
    logic [AW-1:0]     wr_addr;
    t_cell             wr_data;
    logic              calc_done;
    t_cell             calc_cell;

    always_comb begin
        unique case (r_state)
            S_RD0:   begin rd_addr_a = {r_y, r_x};  rd_addr_b = {r_y, x_lo}; end
            S_RD1:   begin rd_addr_a = {r_y, x_hi}; rd_addr_b = {y_lo, r_x}; end
            S_RD2:   begin rd_addr_a = {y_hi, r_x}; rd_addr_b = {r_y, r_x};  end
            default: begin rd_addr_a = {in_y, in_x}; rd_addr_b = {in_y, in_x}; end
        endcase
        dat_a = t_cell'(rd_a[r_bank]);
        dat_b = t_cell'(rd_b[r_bank]);

        wr_en   = 1'b0;
        wr_bank = r_bank;
        wr_addr = r_addr;
        wr_data = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_cnt;
            end
            S_PT: begin
                wr_en          = (r_mode == MODE_ADD);
                wr_data.foam   = dat_a.foam;
                wr_data.height = sat32(64'(dat_a.height) + 64'(r_dh));
                wr_data.vel    = sat32(64'(dat_a.vel) + 64'(r_dv));
            end
            S_CALC: begin
                wr_en   = calc_done;
                wr_bank = ~r_bank;
                wr_addr = {r_y, r_x};
                wr_data = calc_cell;
            end
            default: ;
        endcase
    end

    for (genvar b = 0; b < 2; b++) begin : g_bank
        wgs_ram #(
            .WIDTH (CELL_W),
            .DEPTH (CELLS)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (wr_en && (wr_bank == 1'(b))),
            .i_waddr   (wr_addr),
            .i_wdata   (wr_data),
            .i_raddr_a (rd_addr_a),
            .i_raddr_b (rd_addr_b),
            .o_rdata_a (rd_a[b]),
            .o_rdata_b (rd_b[b])
        );
    end

    wgs_cell_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_RD3),
        .i_cfg   (r_cfg),
        .i_cent  (r_cent),
        .i_hsum  (r_hsum),
        .i_fsum  (r_fsum),
        .i_fade  (r_fade),
        .o_done  (calc_done),
        .o_cell  (calc_cell)
    );

    // ---------------- sequencer ----------------
    // result moves into the output register once that register is free
    logic out_load;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_bank      <= 1'b0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load)           r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == AW'(CELLS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_xfer) begin
                        r_mode <= s_axis_tuser;
                        r_addr <= {in_y, in_x};
                        r_dh   <= s_axis_tdata[47:16];
                        r_dv   <= s_axis_tdata[79:48];
                        r_res  <= '0;
                        r_x    <= '0;
                        r_y    <= '0;
                        unique case (s_axis_tuser)
                            MODE_ADD, MODE_READ: r_state <= S_PT;
                            MODE_STEP:           r_state <= S_RD0;
                            default:             r_state <= S_DONE;
                        endcase
                    end
                end
                S_PT: begin
                    if (r_mode == MODE_READ) r_res <= dat_a;
                    r_state <= S_DONE;
                end
                S_RD0: begin
                    r_fade  <= fade_of(edge_d);
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_cent  <= dat_a;
                    r_hsum  <= 34'(dat_b.height);
                    r_fsum  <= 18'(dat_b.foam);
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_hsum  <= r_hsum + 34'(dat_a.height) + 34'(dat_b.height);
                    r_fsum  <= r_fsum + 18'(dat_a.foam) + 18'(dat_b.foam);
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_hsum  <= r_hsum + 34'(dat_a.height);
                    r_fsum  <= r_fsum + 18'(dat_a.foam);
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (calc_done) begin
                        if (r_x == MAXC) begin
                            r_x <= '0;
                            r_y <= r_y + 1'b1;
                        end else begin
                            r_x <= r_x + 1'b1;
                        end
                        if (r_x == MAXC && r_y == MAXC) begin
                            r_bank  <= ~r_bank;   // next grid becomes current
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RD0;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_data.foam, r_out_data.vel, r_out_data.height};

`ifndef SYNTHESIS
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        calc_done |-> (r_state == S_CALC))
        else $error("cell unit finished outside the scan wait");

    a_write_other_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && r_state == S_CALC) |-> (wr_bank != r_bank))
        else $error("substep wrote into the bank it reads");

    a_bank_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bank != $past(r_bank)) |-> ($past(r_state) == S_CALC && r_state == S_DONE))
        else $error("bank swap outside end of substep");
`endif

endmodule
